// File: sv/irn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irn_pkg
// shared types, constants and helpers of the nearest-neighbour image rotator
// ----------------------------------------------------------------------------
package irn_pkg;

  localparam int DEF_MAX_WIDTH      = 256;
  localparam int DEF_MAX_HEIGHT     = 256;
  localparam int DEF_TRIG_FRAC_BITS = 14;

  localparam int POS_W    = 8;
  localparam int RGB_W    = 24;
  localparam int SIZE_W   = 9;
  localparam int TRIG_W   = 16;
  localparam int CFG_W    = 16;
  localparam int DELTA_W  = SIZE_W + 2;
  localparam int PROD_W   = DELTA_W + TRIG_W;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SIZE_W-1:0]        SIZE_RESET = 9'd256;
  localparam logic signed [TRIG_W-1:0] COS_RESET  = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SIN_RESET  = 16'sd0;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_COS_ANGLE    = 2'd2,
    CFG_SIN_ANGLE    = 2'd3
  } irn_cfg_idx_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } irn_req_t;

  typedef struct packed {
    logic [SIZE_W-1:0]        width;
    logic [SIZE_W-1:0]        height;
    logic signed [TRIG_W-1:0] cos_angle;
    logic signed [TRIG_W-1:0] sin_angle;
  } irn_cfg_t;

  typedef struct packed {
    irn_req_t                  kind;
    logic                      skip;
    logic [POS_W-1:0]          x;
    logic [POS_W-1:0]          y;
    logic signed [DELTA_W-1:0] dx2;
    logic signed [DELTA_W-1:0] dy2;
    logic [RGB_W-1:0]          rgb;
  } irn_item_t;

  function automatic logic [SIZE_W-1:0] irn_clamp(input logic [SIZE_W-1:0] v,
                                                  input int maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (int'(v) > maxv) begin
      r = SIZE_W'(maxv);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/irn_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irn_if
// valid/ready channels for request beats and result beats
// ----------------------------------------------------------------------------
interface irn_in_if;
  import irn_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [RGB_W-1:0]   pixel_rgb;

  modport source (output valid, req_type, pos_x, pos_y, pixel_rgb, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, pixel_rgb, output ready);
endinterface

interface irn_out_if;
  import irn_pkg::*;
  logic               valid;
  logic               ready;
  logic [RGB_W-1:0]   out_rgb;
  logic               out_of_range;

  modport source (output valid, out_rgb, out_of_range, input ready);
  modport sink   (input valid, out_rgb, out_of_range, output ready);
endinterface
`default_nettype wire

// File: sv/irn_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irn_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module irn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/irn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irn_front
// takes request beats, classifies loads and queries and centres coordinates
// ----------------------------------------------------------------------------
module irn_front #(
  parameter int MAX_WIDTH  = irn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = irn_pkg::DEF_MAX_HEIGHT
) (
  irn_in_if.sink                      in_chan,
  input  wire irn_pkg::irn_cfg_t      cfg,
  input  wire logic                   queue_full,
  output logic                        push,
  output irn_pkg::irn_item_t          item
);
  import irn_pkg::*;

  logic load_in_store;
  logic query_outside;

  assign in_chan.ready = !queue_full;
  assign push          = in_chan.valid && !queue_full;

  always_comb begin
    load_in_store = (int'(in_chan.pos_x) < MAX_WIDTH) && (int'(in_chan.pos_y) < MAX_HEIGHT);
    query_outside = ({1'b0, in_chan.pos_x} >= cfg.width) ||
                    ({1'b0, in_chan.pos_y} >= cfg.height);
    item.kind = irn_req_t'(in_chan.req_type);
    item.skip = (item.kind == REQ_LOAD) ? !load_in_store : query_outside;
    item.x    = in_chan.pos_x;
    item.y    = in_chan.pos_y;
    item.dx2  = $signed({2'b00, in_chan.pos_x, 1'b0}) - $signed({2'b00, cfg.width});
    item.dy2  = $signed({2'b00, in_chan.pos_y, 1'b0}) - $signed({2'b00, cfg.height});
    item.rgb  = in_chan.pixel_rgb;
  end

endmodule
`default_nettype wire

// File: sv/irn_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irn_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
module irn_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire irn_pkg::irn_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output irn_pkg::irn_item_t      head
);
  import irn_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  irn_item_t          store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W:0]     count_r;
  logic [PTR_W:0]     count_nxt;

  assign full  = (count_r == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = store_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && !empty)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop && !empty) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// File: sv/irn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irn_back
// rotation multiplies, bounds check, ram access: one beat a cycle if unstalled
// ----------------------------------------------------------------------------
module irn_back #(
  parameter int MAX_WIDTH      = irn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = irn_pkg::DEF_MAX_HEIGHT,
  parameter int TRIG_FRAC_BITS = irn_pkg::DEF_TRIG_FRAC_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire irn_pkg::irn_cfg_t  cfg,
  input  wire logic               queue_empty,
  input  wire irn_pkg::irn_item_t queue_head,
  output logic                    pop,
  irn_out_if.source               out_chan
);
  import irn_pkg::*;

  localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = XW + YW;
  localparam int BASEW = SIZE_W + 1 + TRIG_FRAC_BITS;
  localparam int SW    = ((PROD_W > BASEW) ? PROD_W : BASEW) + 2;

  logic adv;

  // stage 1: products
  logic                      s1_valid_r;
  irn_req_t                  s1_kind_r;
  logic                      s1_skip_r;
  logic [AW-1:0]             s1_addr_r;
  logic [RGB_W-1:0]          s1_rgb_r;
  logic signed [PROD_W-1:0]  s1_xc_r;
  logic signed [PROD_W-1:0]  s1_ys_r;
  logic signed [PROD_W-1:0]  s1_xs_r;
  logic signed [PROD_W-1:0]  s1_yc_r;

  // stage 2: source point and store address
  logic                      s2_valid_r;
  irn_req_t                  s2_kind_r;
  logic                      s2_hit_r;
  logic                      s2_skip_r;
  logic [AW-1:0]             s2_addr_r;
  logic [RGB_W-1:0]          s2_rgb_r;

  // stage 3: result
  logic                      s3_valid_r;
  logic                      s3_hit_r;

  logic signed [SW-1:0]      w_base;
  logic signed [SW-1:0]      h_base;
  logic signed [SW-1:0]      nx;
  logic signed [SW-1:0]      ny;
  logic                      hit;
  logic [SIZE_W-1:0]         sx;
  logic [SIZE_W-1:0]         sy;
  logic [AW-1:0]             src_addr;

  logic                      ram_we;
  logic                      ram_re;
  logic [RGB_W-1:0]          ram_rdata;

  assign adv = !s3_valid_r || out_chan.ready;
  assign pop = adv && !queue_empty;

  always_comb begin
    w_base = $signed({{(SW - SIZE_W){1'b0}}, cfg.width})  <<< TRIG_FRAC_BITS;
    h_base = $signed({{(SW - SIZE_W){1'b0}}, cfg.height}) <<< TRIG_FRAC_BITS;
    nx  = SW'(s1_xc_r) - SW'(s1_ys_r) + w_base;
    ny  = SW'(s1_xs_r) + SW'(s1_yc_r) + h_base;
    hit = !s1_skip_r && !nx[SW-1] && !ny[SW-1] &&
          (nx < (w_base <<< 1)) && (ny < (h_base <<< 1));
    sx  = nx[TRIG_FRAC_BITS+1 +: SIZE_W];
    sy  = ny[TRIG_FRAC_BITS+1 +: SIZE_W];
    src_addr = {YW'(sy), XW'(sx)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= !queue_empty;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r && (s2_kind_r == REQ_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= queue_head.kind;
      s1_skip_r <= queue_head.skip;
      s1_addr_r <= {YW'(queue_head.y), XW'(queue_head.x)};
      s1_rgb_r  <= queue_head.rgb;
      s1_xc_r   <= queue_head.dx2 * cfg.cos_angle;
      s1_ys_r   <= queue_head.dy2 * cfg.sin_angle;
      s1_xs_r   <= queue_head.dx2 * cfg.sin_angle;
      s1_yc_r   <= queue_head.dy2 * cfg.cos_angle;
      s2_kind_r <= s1_kind_r;
      s2_skip_r <= s1_skip_r;
      s2_hit_r  <= hit;
      s2_addr_r <= (s1_kind_r == REQ_LOAD) ? s1_addr_r : src_addr;
      s2_rgb_r  <= s1_rgb_r;
      s3_hit_r  <= s2_hit_r;
    end
  end

  assign ram_we = adv && s2_valid_r && (s2_kind_r == REQ_LOAD) && !s2_skip_r;
  assign ram_re = adv && s2_valid_r && (s2_kind_r == REQ_QUERY) && s2_hit_r;

  irn_ram #(
    .WIDTH (RGB_W),
    .DEPTH (2 ** AW)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_addr_r),
    .wdata (s2_rgb_r),
    .re    (ram_re),
    .raddr (s2_addr_r),
    .rdata (ram_rdata)
  );

  assign out_chan.valid        = s3_valid_r;
  assign out_chan.out_rgb      = s3_hit_r ? ram_rdata : '0;
  assign out_chan.out_of_range = !s3_hit_r;

endmodule
`default_nettype wire

// File: sv/image_rotate_nearest_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_rotate_nearest_top
// nearest-neighbour image rotation about the centre by inverse mapping
// ----------------------------------------------------------------------------
// Load beats write one pixel into the frame store; query beats map an output
// position back through the programmed cosine and sine and return the stored
// source pixel, or black with out_of_range set when the source lies outside
// the active image. One beat of either kind is taken every clock cycle while
// the queue has room; a query's result passes the queue entry, the registered
// products, the registered source point and store address and the registered
// frame store read before it is offered. Loads and queries reach the store in
// order, one access per cycle as the pipeline advances. The frame store is not
// cleared: a query must only land on pixels that were loaded. Configuration
// must be written while idle; the block itself does not enforce this.
module image_rotate_nearest_top #(
  parameter int MAX_WIDTH      = irn_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = irn_pkg::DEF_MAX_HEIGHT,
  parameter int TRIG_FRAC_BITS = irn_pkg::DEF_TRIG_FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  irn_in_if.sink                     in_chan,
  irn_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire irn_pkg::irn_cfg_idx_t cfg_index,
  input  wire logic [irn_pkg::CFG_W-1:0] cfg_data
);
  import irn_pkg::*;

  irn_cfg_t  cfg_r;
  irn_item_t push_item;
  irn_item_t head_item;
  logic      push;
  logic      queue_full;
  logic      queue_empty;
  logic      pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width     <= irn_clamp(SIZE_RESET, MAX_WIDTH);
      cfg_r.height    <= irn_clamp(SIZE_RESET, MAX_HEIGHT);
      cfg_r.cos_angle <= COS_RESET;
      cfg_r.sin_angle <= SIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          cfg_r.width <= irn_clamp(cfg_data[SIZE_W-1:0], MAX_WIDTH);
        end
        CFG_IMAGE_HEIGHT: begin
          cfg_r.height <= irn_clamp(cfg_data[SIZE_W-1:0], MAX_HEIGHT);
        end
        CFG_COS_ANGLE: begin
          cfg_r.cos_angle <= $signed(cfg_data[TRIG_W-1:0]);
        end
        CFG_SIN_ANGLE: begin
          cfg_r.sin_angle <= $signed(cfg_data[TRIG_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  irn_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .in_chan    (in_chan),
    .cfg        (cfg_r),
    .queue_full (queue_full),
    .push       (push),
    .item       (push_item)
  );

  irn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head_item)
  );

  irn_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .queue_empty (queue_empty),
    .queue_head  (head_item),
    .pop         (pop),
    .out_chan    (out_chan)
  );

endmodule
`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the nearest-neighbour image rotator: a directed
// table followed by random configurations, each loading pixels and querying
// rotated positions; every result beat is checked against the table's expected
// value or a local model of the inverse mapping and the frame store
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import irn_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_BEATS  = 1200;
  localparam int FRAC          = DEF_TRIG_FRAC_BITS;
  localparam int STORE_W       = DEF_MAX_WIDTH;
  localparam int STORE_H       = DEF_MAX_HEIGHT;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic             oor;
  } pixel_res_t;

  typedef struct packed {
    bit               is_cfg;
    irn_cfg_idx_t     idx;
    logic [CFG_W-1:0] data;
    irn_req_t         kind;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [RGB_W-1:0] rgb;
    bit               fixed;
    pixel_res_t       want;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  irn_cfg_idx_t     cfg_index;
  logic [CFG_W-1:0] cfg_data;

  irn_in_if  req_ch ();
  irn_out_if res_ch ();

  image_rotate_nearest_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_ch),
    .out_chan  (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [RGB_W-1:0] pixel_store   [STORE_W*STORE_H];
  bit               pixel_written [STORE_W*STORE_H];
  int               img_w, img_h, cos_q, sin_q;
  pixel_res_t       pending_pixels [$];
  int               mismatches  = 0;
  int               beats_sent  = 0;
  int               quiet_cycles = 0;
  bit               calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clamp_dim(input logic [CFG_W-1:0] d, input int maxv);
    int v;
    v = int'(d[SIZE_W-1:0]);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void set_shadow(input irn_cfg_idx_t idx, input logic [CFG_W-1:0] d);
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = clamp_dim(d, STORE_W);
      CFG_IMAGE_HEIGHT: img_h = clamp_dim(d, STORE_H);
      CFG_COS_ANGLE:    cos_q = int'($signed(d[TRIG_W-1:0]));
      CFG_SIN_ANGLE:    sin_q = int'($signed(d[TRIG_W-1:0]));
      default: ;
    endcase
  endfunction

  // inverse map in doubled coordinates, src is -1 when no pixel is read
  function automatic void rotate_fetch(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                       output pixel_res_t res, output int src);
    longint w, h, dx2, dy2, one, nx, ny;
    res.rgb = '0;
    res.oor = 1'b1;
    src = -1;
    if (int'(x) >= img_w || int'(y) >= img_h) return;
    w   = img_w;
    h   = img_h;
    one = longint'(1) << FRAC;
    dx2 = 2 * longint'(x) - w;
    dy2 = 2 * longint'(y) - h;
    nx  = dx2 * cos_q - dy2 * sin_q + w * one;
    ny  = dx2 * sin_q + dy2 * cos_q + h * one;
    if (nx >= 0 && nx < 2 * w * one && ny >= 0 && ny < 2 * h * one) begin
      src = int'(ny >>> (FRAC + 1)) * STORE_W + int'(nx >>> (FRAC + 1));
      res.rgb = pixel_store[src];
      res.oor = 1'b0;
    end
  endfunction

  function automatic plan_row_t cfg_row(input irn_cfg_idx_t idx, input logic [CFG_W-1:0] d);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = d;
    return r;
  endfunction

  function automatic plan_row_t beat_row(input irn_req_t kind, input logic [POS_W-1:0] x,
                                         input logic [POS_W-1:0] y, input logic [RGB_W-1:0] rgb,
                                         input bit fixed, input logic [RGB_W-1:0] exp_rgb,
                                         input logic exp_oor);
    plan_row_t r;
    r = '0;
    r.kind = kind;
    r.x = x;
    r.y = y;
    r.rgb = rgb;
    r.fixed = fixed;
    r.want.rgb = exp_rgb;
    r.want.oor = exp_oor;
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    int r;
    r = $urandom_range(9);
    if (r <= 5) return CFG_W'($urandom_range(1, 12));
    if (r == 6) return '0;
    if (r == 7) return CFG_W'(STORE_W);
    if (r == 8) return CFG_W'(257 + $urandom_range(254)) | CFG_W'($urandom_range(127) << SIZE_W);
    return CFG_W'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] pick_trig_extreme();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'hC000;
      2:       return 16'h0000;
      3:       return 16'h4000;
      default: return 16'h7FFF;
    endcase
  endfunction

  // beats are driven from the falling edge, handshake seen at the rising edge
  task automatic send_beat(input irn_req_t kind, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic [RGB_W-1:0] rgb,
                           input bit fixed, input pixel_res_t fixed_res);
    pixel_res_t guess;
    int src;
    while (!calm && $urandom_range(99) < 12) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.pos_x     <= x;
    req_ch.pos_y     <= y;
    req_ch.pixel_rgb <= rgb;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (kind == REQ_LOAD) begin
      pixel_store[int'(y) * STORE_W + int'(x)] = rgb;
      pixel_written[int'(y) * STORE_W + int'(x)] = 1'b1;
    end else if (fixed) begin
      pending_pixels.push_back(fixed_res);
    end else begin
      rotate_fetch(x, y, guess, src);
      pending_pixels.push_back(guess);
    end
    beats_sent++;
    @(negedge clk);
  endtask

  // a source pixel never loaded gets a load beat first
  task automatic issue_query(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
    pixel_res_t guess;
    int src;
    rotate_fetch(x, y, guess, src);
    if (src >= 0 && !pixel_written[src]) begin
      send_beat(REQ_LOAD, POS_W'(src % STORE_W), POS_W'(src / STORE_W), RGB_W'($urandom),
                1'b0, '0);
    end
    send_beat(REQ_QUERY, x, y, RGB_W'($urandom), 1'b0, '0);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input irn_cfg_idx_t idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    set_shadow(idx, d);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] wd, input logic [CFG_W-1:0] hd,
                              input logic [CFG_W-1:0] cd, input logic [CFG_W-1:0] sd);
    settle();
    write_reg(CFG_IMAGE_WIDTH, wd);
    write_reg(CFG_IMAGE_HEIGHT, hd);
    write_reg(CFG_COS_ANGLE, cd);
    write_reg(CFG_SIN_ANGLE, sd);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase();
    logic [CFG_W-1:0] wd, hd, cd, sd;
    logic [POS_W-1:0] x, y;
    real theta;
    int r, n, k;
    wd = pick_size();
    hd = pick_size();
    r = $urandom_range(9);
    if (r <= 5) begin
      theta = real'($urandom_range(359)) * 3.14159265358979 / 180.0;
      cd = CFG_W'($rtoi(16384.0 * $cos(theta)));
      sd = CFG_W'($rtoi(16384.0 * $sin(theta)));
    end else if (r == 6) begin
      k = $urandom_range(3);
      cd = (k == 0) ? 16'h4000 : (k == 2) ? 16'hC000 : 16'h0000;
      sd = (k == 1) ? 16'h4000 : (k == 3) ? 16'hC000 : 16'h0000;
    end else if (r == 7) begin
      cd = CFG_W'($urandom);
      sd = CFG_W'($urandom);
    end else begin
      cd = pick_trig_extreme();
      sd = pick_trig_extreme();
    end
    program_regs(wd, hd, cd, sd);
    // small images are filled first so queries land on loaded pixels
    if (img_w * img_h <= 144) begin
      for (int yy = 0; yy < img_h; yy++) begin
        for (int xx = 0; xx < img_w; xx++) begin
          send_beat(REQ_LOAD, POS_W'(xx), POS_W'(yy), RGB_W'($urandom), 1'b0, '0);
        end
      end
    end
    n = $urandom_range(40, 90);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 50 || r >= 85) begin
        x = POS_W'($urandom_range(255));
        y = POS_W'($urandom_range(255));
      end else begin
        x = POS_W'($urandom_range(img_w - 1));
        y = POS_W'($urandom_range(img_h - 1));
      end
      if (r < 20 || (r >= 85 && r < 90)) begin
        send_beat(REQ_LOAD, x, y, RGB_W'($urandom), 1'b0, '0);
      end else begin
        if (r < 85) begin
          x = POS_W'($urandom_range(img_w - 1));
          y = POS_W'($urandom_range(img_h - 1));
        end
        issue_query(x, y);
      end
    end
  endtask

  always @(negedge clk) begin
    res_ch.ready <= calm || ($urandom_range(99) >= 12);
  end

  always @(posedge clk) begin
    pixel_res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("result beat with nothing pending: out_rgb %06h out_of_range %0b",
               res_ch.out_rgb, res_ch.out_of_range);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (res_ch.out_rgb !== want.rgb) begin
          $error("out_rgb expected %06h actual %06h", want.rgb, res_ch.out_rgb);
          mismatches++;
        end
        if (res_ch.out_of_range !== want.oor) begin
          $error("out_of_range expected %0b actual %0b", want.oor, res_ch.out_of_range);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    plan_row_t plan [$];
    bit in_cfg;
    int phase;
    int target;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_IMAGE_WIDTH;
    cfg_data         = '0;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = REQ_LOAD;
    req_ch.pos_x     = '0;
    req_ch.pos_y     = '0;
    req_ch.pixel_rgb = '0;
    res_ch.ready     = 1'b0;
    img_w  = STORE_W;
    img_h  = STORE_H;
    cos_q  = 16384;
    sin_q  = 0;
    in_cfg = 1'b0;

    // identity after reset, corners of the store
    plan.push_back(beat_row(REQ_LOAD, 8'd0, 8'd0, 24'hFFFFFF, 1'b0, '0, 1'b0));
    plan.push_back(beat_row(REQ_LOAD, 8'd255, 8'd255, 24'h000000, 1'b0, '0, 1'b0));
    plan.push_back(beat_row(REQ_LOAD, 8'd255, 8'd0, 24'h5A5AA5, 1'b0, '0, 1'b0));
    plan.push_back(beat_row(REQ_LOAD, 8'd0, 8'd255, 24'h123456, 1'b0, '0, 1'b0));
    plan.push_back(beat_row(REQ_QUERY, 8'd0, 8'd0, 24'h000000, 1'b1, 24'hFFFFFF, 1'b0));
    plan.push_back(beat_row(REQ_QUERY, 8'd255, 8'd255, 24'hFFFFFF, 1'b1, 24'h000000, 1'b0));
    plan.push_back(beat_row(REQ_QUERY, 8'd255, 8'd0, 24'h0F0F0F, 1'b1, 24'h5A5AA5, 1'b0));
    plan.push_back(beat_row(REQ_QUERY, 8'd0, 8'd255, 24'hF0F0F0, 1'b1, 24'h123456, 1'b0));
    // zero width acts as one, oversized height acts as the maximum
    plan.push_back(cfg_row(CFG_IMAGE_WIDTH, 16'h0000));
    plan.push_back(cfg_row(CFG_IMAGE_HEIGHT, 16'h01FF));
    plan.push_back(beat_row(REQ_QUERY, 8'd1, 8'd0, 24'h000000, 1'b1, 24'h000000, 1'b1));
    plan.push_back(beat_row(REQ_QUERY, 8'd0, 8'd0, 24'h000000, 1'b1, 24'hFFFFFF, 1'b0));
    plan.push_back(beat_row(REQ_QUERY, 8'd0, 8'd255, 24'h000000, 1'b1, 24'h123456, 1'b0));
    // half turn
    plan.push_back(cfg_row(CFG_IMAGE_WIDTH, 16'h0100));
    plan.push_back(cfg_row(CFG_IMAGE_HEIGHT, 16'h0100));
    plan.push_back(cfg_row(CFG_COS_ANGLE, 16'hC000));
    plan.push_back(beat_row(REQ_QUERY, 8'd0, 8'd0, 24'h000000, 1'b1, 24'h000000, 1'b1));
    plan.push_back(beat_row(REQ_QUERY, 8'd1, 8'd1, 24'h000000, 1'b1, 24'h000000, 1'b0));
    // quarter turn
    plan.push_back(cfg_row(CFG_COS_ANGLE, 16'h0000));
    plan.push_back(cfg_row(CFG_SIN_ANGLE, 16'h4000));
    plan.push_back(beat_row(REQ_QUERY, 8'd0, 8'd1, 24'h000000, 1'b1, 24'h5A5AA5, 1'b0));
    plan.push_back(beat_row(REQ_QUERY, 8'd255, 8'd0, 24'h000000, 1'b1, 24'h000000, 1'b1));
    // trig values beyond unit magnitude
    plan.push_back(cfg_row(CFG_COS_ANGLE, 16'h8000));
    plan.push_back(cfg_row(CFG_SIN_ANGLE, 16'h7FFF));
    plan.push_back(beat_row(REQ_QUERY, 8'd0, 8'd0, 24'h000000, 1'b0, '0, 1'b0));
    plan.push_back(beat_row(REQ_QUERY, 8'd128, 8'd128, 24'h000000, 1'b0, '0, 1'b0));
    plan.push_back(beat_row(REQ_QUERY, 8'd255, 8'd255, 24'h000000, 1'b0, '0, 1'b0));
    plan.push_back(beat_row(REQ_QUERY, 8'd37, 8'd200, 24'h000000, 1'b0, '0, 1'b0));
    plan.push_back(cfg_row(CFG_COS_ANGLE, 16'h7FFF));
    plan.push_back(cfg_row(CFG_SIN_ANGLE, 16'h8000));
    plan.push_back(beat_row(REQ_QUERY, 8'd255, 8'd0, 24'h000000, 1'b0, '0, 1'b0));
    plan.push_back(beat_row(REQ_QUERY, 8'd0, 8'd255, 24'h000000, 1'b0, '0, 1'b0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!in_cfg) begin
          settle();
          in_cfg = 1'b1;
        end
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        if (in_cfg) begin
          cfg_we <= 1'b0;
          in_cfg = 1'b0;
        end
        if (plan[i].kind == REQ_QUERY && !plan[i].fixed) begin
          issue_query(plan[i].x, plan[i].y);
        end else begin
          send_beat(plan[i].kind, plan[i].x, plan[i].y, plan[i].rgb, plan[i].fixed,
                    plan[i].want);
        end
      end
    end

    target = beats_sent + RANDOM_BEATS;
    phase = 0;
    while (beats_sent < target) begin
      calm = (phase >= 4 && phase < 7);
      run_phase();
      phase++;
    end
    calm = 1'b0;

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
